>>> hw/rtl/morton_region_next_hop_lookup_assert.svh
// Assertion macros shared by the lookup RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef MORTON_REGION_NEXT_HOP_LOOKUP_ASSERT_SVH
`define MORTON_REGION_NEXT_HOP_LOOKUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MRNHL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define MRNHL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define MRNHL_ASSERT_IMP(lbl, ante, cons)
`define MRNHL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/mrnhl_pkg.sv
// Types and constants for the Morton region next-hop lookup.
// No dependencies.
`default_nettype none

package mrnhl_pkg;

  localparam int CODE_BITS        = 62;
  localparam int SLOT_BITS        = 10;
  localparam int HOP_FIELD_BITS   = 20;
  localparam int COORD_FIELD_BITS = 32;
  localparam int LEVEL_BITS       = 5;
  localparam int COUNT_BITS       = 11;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 32;
  localparam int EXT_BITS         = 65;

  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_QUERY     = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  localparam logic [1:0] QUAD_UL = 2'd0;
  localparam logic [1:0] QUAD_UR = 2'd1;
  localparam logic [1:0] QUAD_LL = 2'd2;
  localparam logic [1:0] QUAD_LR = 2'd3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MIN_X       = 3'd0,
    CFG_MIN_Y       = 3'd1,
    CFG_MAX_X       = 3'd2,
    CFG_MAX_Y       = 3'd3,
    CFG_LEVELS      = 3'd4,
    CFG_ENTRY_COUNT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                               operation;
    logic [SLOT_BITS-1:0]               entry_index;
    logic [CODE_BITS-1:0]               entry_code;
    logic [HOP_FIELD_BITS-1:0]          entry_hop;
    logic signed [COORD_FIELD_BITS-1:0] point_x;
    logic signed [COORD_FIELD_BITS-1:0] point_y;
  } in_t;

  typedef struct packed {
    logic [HOP_FIELD_BITS-1:0] next_hop;
    logic [SLOT_BITS-1:0]      match_slot;
    logic [CODE_BITS-1:0]      query_code;
    logic                      status;
  } out_t;

  typedef struct packed {
    logic signed [COORD_FIELD_BITS-1:0] min_x;
    logic signed [COORD_FIELD_BITS-1:0] min_y;
    logic signed [COORD_FIELD_BITS-1:0] max_x;
    logic signed [COORD_FIELD_BITS-1:0] max_y;
  } region_t;

  typedef struct packed {
    logic                               start;
    logic [LEVEL_BITS-1:0]              levels;
    logic signed [COORD_FIELD_BITS-1:0] point_x;
    logic signed [COORD_FIELD_BITS-1:0] point_y;
  } enc_req_t;

  typedef struct packed {
    logic                 done;
    logic [CODE_BITS-1:0] code;
  } enc_rsp_t;

  typedef enum logic [1:0] {
    ENC_IDLE,
    ENC_MID,
    ENC_SEL,
    ENC_DONE
  } enc_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC,
    ST_STEP,
    ST_CMP,
    ST_HOP
  } lkp_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/mrnhl_encoder.sv
// Iterative quadrant encoder: each subdivision level has a midpoint step and a select step.
// Depends on mrnhl_pkg.
`default_nettype none
`include "morton_region_next_hop_lookup_assert.svh"

module mrnhl_encoder
  import mrnhl_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire enc_req_t req,
  input  wire region_t  region,
  output enc_rsp_t      rsp
);

  function automatic logic signed [EXT_BITS-1:0] widen(input logic [COORD_FIELD_BITS-1:0] v);
    widen = {{(EXT_BITS-COORD_BITS){v[COORD_BITS-1]}}, v[COORD_BITS-1:0]};
  endfunction

  enc_state_t state_r, state_nxt;

  logic signed [EXT_BITS-1:0] x_r, y_r, lx_r, ly_r, ux_r, uy_r, mx_r, my_r;
  logic signed [EXT_BITS-1:0] x_nxt, y_nxt, lx_nxt, ly_nxt, ux_nxt, uy_nxt, mx_nxt, my_nxt;
  logic [CODE_BITS-1:0]       code_r, code_nxt;
  logic [LEVEL_BITS-1:0]      cnt_r, cnt_nxt;

  logic signed [EXT_BITS-1:0] dx, dy, sx, sy, hx, hy;
  logic                       in_ul, in_ur, in_ll;
  logic [1:0]                 digit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ENC_IDLE: begin
        if (req.start) begin
          state_nxt = (req.levels == '0) ? ENC_DONE : ENC_MID;
        end
      end
      ENC_MID:  state_nxt = ENC_SEL;
      ENC_SEL:  state_nxt = (cnt_r == LEVEL_BITS'(1)) ? ENC_DONE : ENC_MID;
      ENC_DONE: state_nxt = ENC_IDLE;
      default:  state_nxt = ENC_IDLE;
    endcase
  end

  always_comb begin
    dx = ux_r - lx_r;
    dy = uy_r - ly_r;
    sx = dx + EXT_BITS'(dx[EXT_BITS-1]);
    sy = dy + EXT_BITS'(dy[EXT_BITS-1]);
    hx = sx >>> 1;
    hy = sy >>> 1;

    in_ul = (lx_r <= x_r) && (x_r <= mx_r) && (my_r <= y_r) && (y_r <= uy_r);
    in_ur = (mx_r <= x_r) && (x_r <= ux_r) && (my_r <= y_r) && (y_r <= uy_r);
    in_ll = (lx_r <= x_r) && (x_r <= mx_r) && (ly_r <= y_r) && (y_r <= my_r);
    digit = in_ul ? QUAD_UL : in_ur ? QUAD_UR : in_ll ? QUAD_LL : QUAD_LR;

    x_nxt    = x_r;
    y_nxt    = y_r;
    lx_nxt   = lx_r;
    ly_nxt   = ly_r;
    ux_nxt   = ux_r;
    uy_nxt   = uy_r;
    mx_nxt   = mx_r;
    my_nxt   = my_r;
    code_nxt = code_r;
    cnt_nxt  = cnt_r;

    unique case (state_r)
      ENC_IDLE: begin
        if (req.start) begin
          x_nxt    = widen(req.point_x) <<< req.levels;
          y_nxt    = widen(req.point_y) <<< req.levels;
          lx_nxt   = widen(region.min_x) <<< req.levels;
          ly_nxt   = widen(region.min_y) <<< req.levels;
          ux_nxt   = widen(region.max_x) <<< req.levels;
          uy_nxt   = widen(region.max_y) <<< req.levels;
          code_nxt = '0;
          cnt_nxt  = req.levels;
        end
      end
      ENC_MID: begin
        mx_nxt = lx_r + hx;
        my_nxt = ly_r + hy;
      end
      ENC_SEL: begin
        code_nxt = {code_r[CODE_BITS-3:0], digit};
        cnt_nxt  = cnt_r - LEVEL_BITS'(1);
        case (digit)
          QUAD_UL: begin
            ly_nxt = my_r;
            ux_nxt = mx_r;
          end
          QUAD_UR: begin
            lx_nxt = mx_r;
            ly_nxt = my_r;
          end
          QUAD_LL: begin
            ux_nxt = mx_r;
            uy_nxt = my_r;
          end
          default: begin
            lx_nxt = mx_r;
            uy_nxt = my_r;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp.done = (state_r == ENC_DONE);
    rsp.code = code_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    lx_r   <= lx_nxt;
    ly_r   <= ly_nxt;
    ux_r   <= ux_nxt;
    uy_r   <= uy_nxt;
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    code_r <= code_nxt;
    cnt_r  <= cnt_nxt;
  end

  `MRNHL_ASSERT_NXT(a_done_single, rsp.done, !rsp.done)
  `MRNHL_ASSERT_IMP(a_sel_has_level, state_r == ENC_SEL, cnt_r != '0)
  `MRNHL_ASSERT_IMP(a_start_when_idle, req.start, state_r == ENC_IDLE)

endmodule

`default_nettype wire

>>> hw/rtl/morton_region_next_hop_lookup.sv
// Morton region next-hop lookup: table memories, binary search, config registers.
// Depends on mrnhl_pkg and mrnhl_encoder.
//
//   port group  dir  handshake                payload
//   in_         in   start high, busy low     in_data (in_t)
//   out_        out  out_valid, one cycle     out_data (out_t)
//   cfg_        in   cfg_valid & cfg_ready    cfg_index, cfg_data
//
// A load writes both table memories when accepted and gives no result; busy stays low.
// A query runs the encoder, then the probes, being the binary search steps (at most
// log2(TABLE_DEPTH) + 1), then a hop read; the encoder takes a midpoint and a select
// step per level and each probe is one read of the code memory plus a compare.
// The result is shown one cycle, with busy already low. Reset clears control
// and config registers only; the table is undefined until loaded.
`default_nettype none
`include "morton_region_next_hop_lookup_assert.svh"

module morton_region_next_hop_lookup
  import mrnhl_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int HOP_BITS    = 20,
  parameter int COORD_BITS  = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire in_t                       in_data,
  output logic                           out_valid,
  output out_t                           out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int NW   = IW + 1;
  localparam int CMPW = (NW > COUNT_BITS) ? NW : COUNT_BITS;

  region_t               region_r;
  logic [LEVEL_BITS-1:0] levels_r;
  logic [COUNT_BITS-1:0] entry_count_r;

  lkp_state_t           state_r, state_nxt;
  logic [IW-1:0]        left_r, left_nxt, right_r, right_nxt, mid_r, mid_nxt;
  logic [IW-1:0]        slot_r, slot_nxt;
  logic                 final_r, final_nxt;
  logic [CODE_BITS-1:0] qcode_r, qcode_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  logic [CODE_BITS-1:0] code_mem [TABLE_DEPTH];
  logic [HOP_BITS-1:0]  hop_mem  [TABLE_DEPTH];
  logic [CODE_BITS-1:0] code_q;
  logic [HOP_BITS-1:0]  hop_q;

  logic           in_acc, query_go, load_we;
  logic [IW-1:0]  wr_addr, code_addr, hop_addr;
  logic           code_rd_en, hop_rd_en;
  logic [NW-1:0]  count_lim, mid_sum;
  logic [CMPW-1:0] count_wide;
  logic [IW-1:0]  mid_c, slot_sel;

  enc_req_t enc_req;
  enc_rsp_t enc_rsp;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy && !start;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_acc   = start && !busy;
  assign query_go = in_acc && (in_data.operation == OP_QUERY);
  assign load_we  = in_acc && (in_data.operation == OP_LOAD)
                    && (CMPW'(in_data.entry_index) < CMPW'(TABLE_DEPTH));
  assign wr_addr  = IW'(in_data.entry_index);

  assign count_wide = CMPW'(entry_count_r);
  assign count_lim  = (count_wide > CMPW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(count_wide);

  assign mid_sum  = {1'b0, left_r} + {1'b0, right_r};
  assign mid_c    = mid_sum[NW-1:1];
  assign slot_sel = (qcode_r >= code_q) ? right_r : left_r;

  always_comb begin
    enc_req.start   = query_go;
    enc_req.levels  = levels_r;
    enc_req.point_x = in_data.point_x;
    enc_req.point_y = in_data.point_y;
  end

  mrnhl_encoder #(
    .COORD_BITS(COORD_BITS)
  ) u_encoder (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (enc_req),
    .region (region_r),
    .rsp    (enc_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r      <= '0;
      levels_r      <= '0;
      entry_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MIN_X:       region_r.min_x <= cfg_data;
        CFG_MIN_Y:       region_r.min_y <= cfg_data;
        CFG_MAX_X:       region_r.max_x <= cfg_data;
        CFG_MAX_Y:       region_r.max_y <= cfg_data;
        CFG_LEVELS:      levels_r       <= cfg_data[LEVEL_BITS-1:0];
        CFG_ENTRY_COUNT: entry_count_r  <= cfg_data[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (query_go) begin
          state_nxt = ST_ENC;
        end
      end
      ST_ENC: begin
        if (enc_rsp.done) begin
          state_nxt = (count_lim == '0) ? ST_IDLE : ST_STEP;
        end
      end
      ST_STEP: state_nxt = ST_CMP;
      ST_CMP:  state_nxt = final_r ? ST_HOP : ST_STEP;
      ST_HOP:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    left_nxt      = left_r;
    right_nxt     = right_r;
    mid_nxt       = mid_r;
    slot_nxt      = slot_r;
    final_nxt     = final_r;
    qcode_nxt     = qcode_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    code_rd_en    = 1'b0;
    code_addr     = mid_c;
    hop_rd_en     = 1'b0;
    hop_addr      = slot_sel;

    unique case (state_r)
      ST_ENC: begin
        if (enc_rsp.done) begin
          qcode_nxt = enc_rsp.code;
          left_nxt  = '0;
          right_nxt = IW'(count_lim - NW'(1));
          if (count_lim == '0) begin
            out_nxt.next_hop   = '0;
            out_nxt.match_slot = '0;
            out_nxt.query_code = enc_rsp.code;
            out_nxt.status     = STATUS_EMPTY;
            out_valid_nxt      = 1'b1;
          end
        end
      end
      ST_STEP: begin
        mid_nxt    = mid_c;
        final_nxt  = (mid_c == left_r);
        code_rd_en = 1'b1;
        code_addr  = (mid_c == left_r) ? right_r : mid_c;
      end
      ST_CMP: begin
        if (final_r) begin
          slot_nxt  = slot_sel;
          hop_rd_en = 1'b1;
        end else if (qcode_r < code_q) begin
          right_nxt = mid_r - IW'(1);
        end else begin
          left_nxt = mid_r;
        end
      end
      ST_HOP: begin
        out_nxt.next_hop   = HOP_FIELD_BITS'(hop_q);
        out_nxt.match_slot = SLOT_BITS'(slot_r);
        out_nxt.query_code = qcode_r;
        out_nxt.status     = STATUS_OK;
        out_valid_nxt      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
    mid_r   <= mid_nxt;
    slot_r  <= slot_nxt;
    final_r <= final_nxt;
    qcode_r <= qcode_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      code_mem[wr_addr] <= in_data.entry_code;
      hop_mem[wr_addr]  <= HOP_BITS'(in_data.entry_hop);
    end
    if (code_rd_en) begin
      code_q <= code_mem[code_addr];
    end
    if (hop_rd_en) begin
      hop_q <= hop_mem[hop_addr];
    end
  end

  `MRNHL_ASSERT_IMP(a_result_when_idle, out_valid, !busy)
  `MRNHL_ASSERT_NXT(a_query_goes_busy, start && !busy && (in_data.operation == OP_QUERY), busy)
  `MRNHL_ASSERT_NXT(a_load_no_result, start && !busy && (in_data.operation == OP_LOAD), !out_valid)
  `MRNHL_ASSERT_IMP(a_search_window, state_r == ST_STEP, left_r <= right_r)

endmodule

`default_nettype wire
